// ----- rtl/core/krse_pkg.sv -----
// krse_pkg: shared types and codes for the keyboard report slot engine
// holds transaction payload structs, command/mode enums and slot unit structs
// no dependencies
`default_nettype none

package krse_pkg;

   typedef enum logic [2:0] {
      KIND_ADD       = 3'd0,
      KIND_DELETE    = 3'd1,
      KIND_RETRIGGER = 3'd2,
      KIND_SEND      = 3'd3,
      KIND_QUERY     = 3'd4,
      KIND_CLEAR     = 3'd5,
      KIND_RESET_ALL = 3'd6,
      KIND_SET_MODE  = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      MODE_AUTO    = 2'd0,
      MODE_6KRO    = 2'd1,
      MODE_UPGRADE = 2'd2,
      MODE_NKRO    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      SCAN_ADD   = 2'd0,
      SCAN_DEL   = 2'd1,
      SCAN_FIND  = 2'd2,
      SCAN_EMPTY = 2'd3
   } scan_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ADD,
      ST_SCAN,
      ST_SCAN_DONE,
      ST_DEL_TAIL,
      ST_SEND_TAIL,
      ST_REPLAY,
      ST_RESULT
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  keycode;
      logic        boot_ready;
      logic        nkro_ready;
      mode_type    new_mode;
   } req_type;

   typedef struct packed {
      logic [47:0] boot_keys;
      logic [7:0]  nkro_byte;
      logic [4:0]  byte_index;
      logic        sent_boot;
      logic        sent_nkro;
      logic        busy_res;
      logic        found;
      mode_type    mode_now;
      logic        last;
   } rsp_type;

   // one slot worth of operands for the shared slot unit
   typedef struct packed {
      scan_op_type op;
      logic [7:0]  key;
      logic [7:0]  age;
      logic [7:0]  pending;
      logic [7:0]  keycode;
      logic [7:0]  max_age;
   } slot_in_type;

   typedef struct packed {
      logic [7:0]  key;
      logic [7:0]  age;
      logic [7:0]  pending;
      logic        hit;
      logic        older;
   } slot_out_type;

endpackage

`default_nettype wire

// ----- rtl/core/krse_slot_unit.sv -----
// krse_slot_unit: shared per-slot operation unit (place, age, remove, match)
// one slot is processed per cycle under the top level sequencer
// depends on krse_pkg
`default_nettype none

module krse_slot_unit (
   input  krse_pkg::slot_in_type  unit_in,
   output krse_pkg::slot_out_type unit_out
);
   import krse_pkg::*;

   always_comb begin
      unit_out.key     = unit_in.key;
      unit_out.age     = unit_in.age;
      unit_out.pending = unit_in.pending;
      unit_out.hit     = 1'b0;
      case (unit_in.op)
         SCAN_ADD: begin
            // empty slot or same key takes the pending key
            if (unit_in.key == 8'd0 ||
                (unit_in.key == unit_in.pending && unit_in.pending != 8'd0)) begin
               unit_out.key     = unit_in.pending;
               unit_out.age     = 8'd0;
               unit_out.pending = 8'd0;
            end else begin
               unit_out.age = unit_in.age + 8'd1;
            end
         end
         SCAN_DEL: begin
            if (unit_in.key == unit_in.keycode) begin
               unit_out.key = 8'd0;
            end
            unit_out.age = unit_in.age - 8'd1;
         end
         SCAN_FIND: begin
            unit_out.hit = (unit_in.key == unit_in.keycode);
         end
         SCAN_EMPTY: begin
            unit_out.hit = (unit_in.key != 8'd0);
         end
         default: begin
            unit_out.hit = 1'b0;
         end
      endcase
      // strictly greater keeps the first oldest slot
      unit_out.older = (unit_out.age > unit_in.max_age);
   end

endmodule

`default_nettype wire

// ----- rtl/core/keyboard_report_slot_engine.sv -----
// keyboard_report_slot_engine: boot key report slots, nkro bitmap and send sequencer
// top level, instantiates krse_slot_unit
// depends on krse_pkg
`default_nettype none

// Keeps a SLOTS-entry boot key report (keycode plus wrapping 8-bit age per slot),
// a BITMAP_BYTES-byte nkro bitmap, a mode (auto, 6kro, upgrade, nkro), a dirty
// flag and a replay list of up to REPLAY_DEPTH retriggered keys. One request
// transaction is taken at a time: req_stall is high from acceptance until the
// last response transaction of that request has been loaded into the response
// register. The slots are walked one per cycle through a single shared slot unit.
// An add in auto or 6kro mode, a delete outside nkro mode and a slot query walk
// all slots; an add or delete in upgrade or nkro mode, or with a zero key, does
// not. A dirty send in upgrade mode walks the slots for the empty-slot check,
// and a dirty send with no endpoint busy then replays the list; each replayed
// key walks the slots through the same slot unit in auto or 6kro mode, unless
// it is zero. A send that posts the nkro report gives BITMAP_BYTES response
// transactions, one bitmap byte per cycle while the response side does not stall.
// Every other request gives exactly one response transaction, marked last.
// boot_keys, the sent flags and the bitmap bytes of a send show the report as
// posted, before the replay; mode_now shows the mode after the request.

module keyboard_report_slot_engine #(
   parameter int SLOTS        = 6,
   parameter int BITMAP_BYTES = 32,
   parameter int REPLAY_DEPTH = 6
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  krse_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output krse_pkg::rsp_type rsp_data
);
   import krse_pkg::*;

   localparam int SI_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BI_W       = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
   localparam int RI_W       = (REPLAY_DEPTH > 1) ? $clog2(REPLAY_DEPTH) : 1;
   localparam int RC_W       = $clog2(REPLAY_DEPTH + 1);
   localparam int BOOT_SLOTS = (SLOTS < 6) ? SLOTS : 6;

   // sequencer
   state_type   state_ff, state_in;

   // architectural state
   mode_type    mode_ff, mode_in;
   logic        dirty_ff, dirty_in;
   logic [7:0]  slot_keys_ff [SLOTS];
   logic [7:0]  slot_keys_in [SLOTS];
   logic [7:0]  slot_ages_ff [SLOTS];
   logic [7:0]  slot_ages_in [SLOTS];
   logic [7:0]  bitmap_ff [BITMAP_BYTES];
   logic [7:0]  bitmap_in [BITMAP_BYTES];
   logic [7:0]  replay_list_ff [REPLAY_DEPTH];
   logic [7:0]  replay_list_in [REPLAY_DEPTH];
   logic [RC_W-1:0] replay_count_ff, replay_count_in;

   // per-transaction working registers
   req_type     cmd_ff, cmd_in;
   logic [7:0]  op_kc_ff, op_kc_in;
   logic [7:0]  pending_ff, pending_in;
   logic [7:0]  max_age_ff, max_age_in;
   logic [SI_W-1:0] oldest_ff, oldest_in;
   logic [SI_W-1:0] scan_idx_ff, scan_idx_in;
   scan_op_type scan_op_ff, scan_op_in;
   logic        hit_ff, hit_in;
   logic        sent_boot_ff, sent_boot_in;
   logic        sent_nkro_ff, sent_nkro_in;
   logic        busy_ff, busy_in;
   logic [RC_W-1:0] replay_idx_ff, replay_idx_in;
   logic [BI_W-1:0] emit_idx_ff, emit_idx_in;
   logic [47:0] snap_keys_ff, snap_keys_in;
   logic [7:0]  snap_bitmap_ff [BITMAP_BYTES];
   logic [7:0]  snap_bitmap_in [BITMAP_BYTES];

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // shared slot unit
   slot_in_type  unit_in;
   slot_out_type unit_out;

   // helpers
   logic [47:0]     cur_keys;
   logic            bm_in_range;
   logic [BI_W-1:0] bm_sel;
   logic [7:0]      bm_mask;
   logic            bm_get;
   logic            out_free;
   logic            emit_last;
   state_type       ret_add;
   logic            want_boot;
   logic            want_nkro;

   krse_slot_unit u_slot_unit (
      .unit_in  (unit_in),
      .unit_out (unit_out)
   );

   // current slots as the boot report, slots past six are not shown
   always_comb begin
      cur_keys = '0;
      for (int i = 0; i < BOOT_SLOTS; i++) begin
         cur_keys[8*i +: 8] = slot_keys_ff[i];
      end
   end

   // bitmap addressing for the key under work
   assign bm_in_range = ({1'b0, op_kc_ff[7:3]} < 6'(BITMAP_BYTES));
   assign bm_sel      = op_kc_ff[3 +: BI_W];
   assign bm_mask     = 8'd1 << op_kc_ff[2:0];
   assign bm_get      = bm_in_range && bitmap_ff[bm_sel][op_kc_ff[2:0]];

   assign unit_in.op      = scan_op_ff;
   assign unit_in.key     = slot_keys_ff[scan_idx_ff];
   assign unit_in.age     = slot_ages_ff[scan_idx_ff];
   assign unit_in.pending = pending_ff;
   assign unit_in.keycode = op_kc_ff;
   assign unit_in.max_age = max_age_ff;

   // response register is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_last = !sent_nkro_ff || (emit_idx_ff == BI_W'(BITMAP_BYTES - 1));
   // an add returns to the replay walk when it came from a send
   assign ret_add   = (cmd_ff.kind == KIND_SEND) ? ST_REPLAY : ST_RESULT;
   assign want_nkro = (mode_ff == MODE_UPGRADE) || (mode_ff == MODE_NKRO);
   assign want_boot = (mode_ff != MODE_NKRO);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer: next state and datapath updates
   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      dirty_in        = dirty_ff;
      slot_keys_in    = slot_keys_ff;
      slot_ages_in    = slot_ages_ff;
      bitmap_in       = bitmap_ff;
      replay_list_in  = replay_list_ff;
      replay_count_in = replay_count_ff;
      cmd_in          = cmd_ff;
      op_kc_in        = op_kc_ff;
      pending_in      = pending_ff;
      max_age_in      = max_age_ff;
      oldest_in       = oldest_ff;
      scan_idx_in     = scan_idx_ff;
      scan_op_in      = scan_op_ff;
      hit_in          = hit_ff;
      sent_boot_in    = sent_boot_ff;
      sent_nkro_in    = sent_nkro_ff;
      busy_in         = busy_ff;
      replay_idx_in   = replay_idx_ff;
      emit_idx_in     = emit_idx_ff;
      snap_keys_in    = snap_keys_ff;
      snap_bitmap_in  = snap_bitmap_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_data;
               op_kc_in     = req_data.keycode;
               hit_in       = 1'b0;
               sent_boot_in = 1'b0;
               sent_nkro_in = 1'b0;
               busy_in      = 1'b0;
               emit_idx_in  = '0;
               state_in     = ST_EXEC;
            end
         end

         ST_EXEC: begin
            case (cmd_ff.kind)
               KIND_ADD: begin
                  state_in = ST_ADD;
               end
               KIND_DELETE, KIND_RETRIGGER: begin
                  state_in = ST_DEL_TAIL;
                  if (op_kc_ff != 8'd0) begin
                     dirty_in = 1'b1;
                     if (mode_ff != MODE_NKRO) begin
                        scan_op_in  = SCAN_DEL;
                        scan_idx_in = '0;
                        state_in    = ST_SCAN;
                     end
                  end
               end
               KIND_SEND: begin
                  // report as posted, before any replay
                  snap_keys_in   = cur_keys;
                  snap_bitmap_in = bitmap_ff;
                  state_in       = ST_RESULT;
                  if (dirty_ff) begin
                     sent_nkro_in = want_nkro && cmd_ff.nkro_ready;
                     sent_boot_in = want_boot && cmd_ff.boot_ready;
                     busy_in      = (want_nkro && !cmd_ff.nkro_ready) ||
                                    (want_boot && !cmd_ff.boot_ready);
                     if (mode_ff == MODE_UPGRADE) begin
                        scan_op_in  = SCAN_EMPTY;
                        scan_idx_in = '0;
                        hit_in      = 1'b0;
                        state_in    = ST_SCAN;
                     end else begin
                        state_in = ST_SEND_TAIL;
                     end
                  end
               end
               KIND_QUERY: begin
                  if (mode_ff == MODE_NKRO) begin
                     hit_in   = bm_get;
                     state_in = ST_RESULT;
                  end else begin
                     scan_op_in  = SCAN_FIND;
                     scan_idx_in = '0;
                     hit_in      = 1'b0;
                     state_in    = ST_SCAN;
                  end
               end
               KIND_CLEAR: begin
                  dirty_in = 1'b1;
                  for (int i = 0; i < SLOTS; i++) begin
                     slot_keys_in[i] = 8'd0;
                  end
                  for (int i = 0; i < BITMAP_BYTES; i++) begin
                     bitmap_in[i] = 8'd0;
                  end
                  state_in = ST_RESULT;
               end
               KIND_RESET_ALL: begin
                  dirty_in        = 1'b1;
                  replay_count_in = '0;
                  for (int i = 0; i < SLOTS; i++) begin
                     slot_keys_in[i] = 8'd0;
                     slot_ages_in[i] = 8'd0;
                  end
                  for (int i = 0; i < BITMAP_BYTES; i++) begin
                     bitmap_in[i] = 8'd0;
                  end
                  state_in = ST_RESULT;
               end
               KIND_SET_MODE: begin
                  mode_in  = cmd_ff.new_mode;
                  state_in = ST_RESULT;
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end

         ST_ADD: begin
            state_in = ret_add;
            if (op_kc_ff != 8'd0) begin
               dirty_in = 1'b1;
               if (mode_ff == MODE_AUTO || mode_ff == MODE_6KRO) begin
                  scan_op_in  = SCAN_ADD;
                  scan_idx_in = '0;
                  pending_in  = op_kc_ff;
                  max_age_in  = 8'd0;
                  oldest_in   = '0;
                  state_in    = ST_SCAN;
               end else if (bm_in_range) begin
                  bitmap_in[bm_sel] = bitmap_ff[bm_sel] | bm_mask;
               end
            end
         end

         ST_SCAN: begin
            // one slot per cycle through the shared unit
            slot_keys_in[scan_idx_ff] = unit_out.key;
            slot_ages_in[scan_idx_ff] = unit_out.age;
            pending_in                = unit_out.pending;
            if (unit_out.hit) begin
               hit_in = 1'b1;
            end
            if (unit_out.older) begin
               max_age_in = unit_out.age;
               oldest_in  = scan_idx_ff;
            end
            if (scan_idx_ff == SI_W'(SLOTS - 1)) begin
               state_in = ST_SCAN_DONE;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end

         ST_SCAN_DONE: begin
            case (scan_op_ff)
               SCAN_ADD: begin
                  state_in = ret_add;
                  if (pending_ff != 8'd0) begin
                     if (mode_ff == MODE_AUTO) begin
                        // report full: upgrade and keep the key in the bitmap
                        mode_in = MODE_UPGRADE;
                        if (bm_in_range) begin
                           bitmap_in[bm_sel] = bitmap_ff[bm_sel] | bm_mask;
                        end
                     end else begin
                        // 6kro: replace the oldest slot
                        slot_keys_in[oldest_ff] = pending_ff;
                        slot_ages_in[oldest_ff] = 8'd0;
                     end
                  end
               end
               SCAN_DEL: begin
                  state_in = ST_DEL_TAIL;
               end
               SCAN_FIND: begin
                  state_in = ST_RESULT;
               end
               SCAN_EMPTY: begin
                  if (!hit_ff) begin
                     mode_in = MODE_NKRO;
                  end
                  state_in = ST_SEND_TAIL;
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end

         ST_DEL_TAIL: begin
            if (op_kc_ff != 8'd0 && bm_in_range) begin
               bitmap_in[bm_sel] = bitmap_ff[bm_sel] & ~bm_mask;
            end
            // retrigger remembers the key, dropped when the list is full
            if (cmd_ff.kind == KIND_RETRIGGER &&
                replay_count_ff < RC_W'(REPLAY_DEPTH)) begin
               replay_list_in[replay_count_ff[RI_W-1:0]] = op_kc_ff;
               replay_count_in = replay_count_ff + 1'b1;
            end
            state_in = ST_RESULT;
         end

         ST_SEND_TAIL: begin
            if (!busy_ff) begin
               dirty_in      = 1'b0;
               replay_idx_in = '0;
               state_in      = ST_REPLAY;
            end else begin
               state_in = ST_RESULT;
            end
         end

         ST_REPLAY: begin
            if (replay_idx_ff < replay_count_ff) begin
               op_kc_in      = replay_list_ff[replay_idx_ff[RI_W-1:0]];
               replay_idx_in = replay_idx_ff + 1'b1;
               state_in      = ST_ADD;
            end else begin
               replay_count_in = '0;
               state_in        = ST_RESULT;
            end
         end

         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.boot_keys  = (cmd_ff.kind == KIND_SEND) ? snap_keys_ff : cur_keys;
               rsp_data_in.nkro_byte  = sent_nkro_ff ? snap_bitmap_ff[emit_idx_ff] : 8'd0;
               rsp_data_in.byte_index = sent_nkro_ff ? 5'(emit_idx_ff) : 5'd0;
               rsp_data_in.sent_boot  = sent_boot_ff;
               rsp_data_in.sent_nkro  = sent_nkro_ff;
               rsp_data_in.busy_res   = busy_ff;
               rsp_data_in.found      = (cmd_ff.kind == KIND_QUERY) && hit_ff;
               rsp_data_in.mode_now   = mode_ff;
               rsp_data_in.last       = emit_last;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and architectural state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_AUTO;
         dirty_ff        <= 1'b0;
         replay_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_keys_ff[i] <= 8'd0;
            slot_ages_ff[i] <= 8'd0;
         end
         for (int i = 0; i < BITMAP_BYTES; i++) begin
            bitmap_ff[i] <= 8'd0;
         end
      end else begin
         mode_ff         <= mode_in;
         dirty_ff        <= dirty_in;
         replay_count_ff <= replay_count_in;
         rsp_valid_ff    <= rsp_valid_in;
         slot_keys_ff    <= slot_keys_in;
         slot_ages_ff    <= slot_ages_in;
         bitmap_ff       <= bitmap_in;
      end
   end

   // payload and working registers, qualified by the sequencer state
   always_ff @(posedge clock) begin
      replay_list_ff <= replay_list_in;
      cmd_ff         <= cmd_in;
      op_kc_ff       <= op_kc_in;
      pending_ff     <= pending_in;
      max_age_ff     <= max_age_in;
      oldest_ff      <= oldest_in;
      scan_idx_ff    <= scan_idx_in;
      scan_op_ff     <= scan_op_in;
      hit_ff         <= hit_in;
      sent_boot_ff   <= sent_boot_in;
      sent_nkro_ff   <= sent_nkro_in;
      busy_ff        <= busy_in;
      replay_idx_ff  <= replay_idx_in;
      emit_idx_ff    <= emit_idx_in;
      snap_keys_ff   <= snap_keys_in;
      snap_bitmap_ff <= snap_bitmap_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // only a send that posted nkro gives a multi-transaction run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.sent_nkro) |-> rsp_data_ff.last)
      else $error("single response transaction not marked last");

   // nkro mode is left only through set mode
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_NKRO &&
       !(state_ff == ST_EXEC && cmd_ff.kind == KIND_SET_MODE)) |=> (mode_ff == MODE_NKRO))
      else $error("nkro mode left without set mode");

   // replay list never overflows
   assert property (@(posedge clock) disable iff (reset)
      replay_count_ff <= RC_W'(REPLAY_DEPTH))
      else $error("replay count beyond list depth");

   // a busy send never reports both endpoints as posted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.busy_res) |->
         !(rsp_data_ff.sent_boot && rsp_data_ff.sent_nkro))
      else $error("busy send claims both reports posted");

endmodule

`default_nettype wire

// ----- verif/krse_report_tracker_pkg.sv -----
// krse_report_tracker_pkg: running model of the key report engine plus result checker
// predicts every response transaction of an accepted request and checks them in order
// depends on krse_pkg
`timescale 1ns / 1ps

package krse_report_tracker_pkg;

   import krse_pkg::*;

   localparam int NUM_SLOTS        = 6;
   localparam int NUM_BITMAP_BYTES = 32;
   localparam int NUM_REPLAY       = 6;
   localparam int MAX_SHOWN        = 10;

   class key_report_tracker;

      logic [7:0] slot_key [NUM_SLOTS];
      logic [7:0] slot_age [NUM_SLOTS];
      logic [7:0] key_map [NUM_BITMAP_BYTES];
      mode_type   mode;
      bit         dirty;
      logic [7:0] replay_key [NUM_REPLAY];
      int         replay_n;

      rsp_type    expected_reports [$];
      int         failures;
      int         checked;

      function new();
         foreach (slot_key[i]) begin
            slot_key[i] = 8'h00;
            slot_age[i] = 8'h00;
         end
         foreach (key_map[i]) key_map[i] = 8'h00;
         foreach (replay_key[i]) replay_key[i] = 8'h00;
         mode     = MODE_AUTO;
         dirty    = 1'b0;
         replay_n = 0;
         failures = 0;
         checked  = 0;
      endfunction

      function void mark_key(logic [7:0] kc, bit on);
         int idx;
         idx = int'(kc) >> 3;
         if (idx >= NUM_BITMAP_BYTES) return;
         key_map[idx][kc[2:0]] = on;
      endfunction

      // first free or matching slot wins, the other occupied slots age by one
      function void place_in_slots(logic [7:0] kc);
         logic [7:0] pending;
         logic [7:0] oldest_age;
         int         oldest;
         pending    = kc;
         oldest     = 0;
         oldest_age = 8'h00;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_key[i] == 8'h00 || (slot_key[i] == pending && pending != 8'h00)) begin
               slot_key[i] = pending;
               slot_age[i] = 8'h00;
               pending     = 8'h00;
            end else begin
               slot_age[i] = slot_age[i] + 8'd1;
            end
         end
         if (pending == 8'h00) return;
         if (mode == MODE_AUTO) begin
            mode = MODE_UPGRADE;
            return;
         end
         if (mode == MODE_6KRO) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_age[i] > oldest_age) begin
                  oldest_age = slot_age[i];
                  oldest     = i;
               end
            end
            slot_key[oldest] = pending;
            slot_age[oldest] = 8'h00;
         end
      endfunction

      function void press_key(logic [7:0] kc);
         if (kc == 8'h00) return;
         dirty = 1'b1;
         if (mode == MODE_6KRO || mode == MODE_AUTO) begin
            place_in_slots(kc);
            if (mode == MODE_UPGRADE) mark_key(kc, 1'b1);
         end else begin
            mark_key(kc, 1'b1);
         end
      endfunction

      function void release_key(logic [7:0] kc);
         if (kc == 8'h00) return;
         dirty = 1'b1;
         if (mode != MODE_NKRO) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_key[i] == kc) slot_key[i] = 8'h00;
               slot_age[i] = slot_age[i] - 8'd1;
            end
         end
         mark_key(kc, 1'b0);
      endfunction

      function void note_request(req_type item);
         logic [47:0] keys_snap;
         logic [7:0]  map_snap [NUM_BITMAP_BYTES];
         bit          sent_b, sent_n, busy, hit, want_b, want_n, any_key;
         int          n, idx;
         rsp_type     want;
         sent_b = 1'b0;
         sent_n = 1'b0;
         busy   = 1'b0;
         hit    = 1'b0;
         case (item.kind)
            KIND_ADD: press_key(item.keycode);
            KIND_DELETE: release_key(item.keycode);
            KIND_RETRIGGER: begin
               release_key(item.keycode);
               if (replay_n < NUM_REPLAY) begin
                  replay_key[replay_n] = item.keycode;
                  replay_n++;
               end
            end
            KIND_SEND: ;
            KIND_QUERY: begin
               if (mode == MODE_NKRO) begin
                  idx = int'(item.keycode) >> 3;
                  if (idx < NUM_BITMAP_BYTES) hit = key_map[idx][item.keycode[2:0]];
               end else begin
                  foreach (slot_key[i]) if (slot_key[i] == item.keycode) hit = 1'b1;
               end
            end
            KIND_CLEAR: begin
               dirty = 1'b1;
               foreach (slot_key[i]) slot_key[i] = 8'h00;
               foreach (key_map[i]) key_map[i] = 8'h00;
            end
            KIND_RESET_ALL: begin
               foreach (slot_key[i]) begin
                  slot_key[i] = 8'h00;
                  slot_age[i] = 8'h00;
               end
               foreach (key_map[i]) key_map[i] = 8'h00;
               replay_n = 0;
               dirty    = 1'b1;
            end
            default: mode = item.new_mode;
         endcase

         keys_snap = '0;
         for (int i = 0; i < NUM_SLOTS && i < 6; i++) keys_snap[8*i +: 8] = slot_key[i];
         map_snap = key_map;

         if (item.kind == KIND_SEND && dirty) begin
            want_b = (mode != MODE_NKRO);
            want_n = (mode == MODE_UPGRADE || mode == MODE_NKRO);
            if (want_n) begin
               if (item.nkro_ready) sent_n = 1'b1;
               else busy = 1'b1;
            end
            if (want_b) begin
               if (item.boot_ready) sent_b = 1'b1;
               else busy = 1'b1;
            end
            any_key = 1'b0;
            foreach (slot_key[i]) if (slot_key[i] != 8'h00) any_key = 1'b1;
            if (mode == MODE_UPGRADE && !any_key) mode = MODE_NKRO;
            if (!busy) begin
               dirty = 1'b0;
               for (int i = 0; i < replay_n; i++) press_key(replay_key[i]);
               replay_n = 0;
            end
         end

         n = sent_n ? NUM_BITMAP_BYTES : 1;
         for (int k = 0; k < n; k++) begin
            want.boot_keys  = keys_snap;
            want.nkro_byte  = sent_n ? map_snap[k] : 8'h00;
            want.byte_index = sent_n ? 5'(k) : 5'd0;
            want.sent_boot  = sent_b;
            want.sent_nkro  = sent_n;
            want.busy_res   = busy;
            want.found      = hit;
            want.mode_now   = mode;
            want.last       = (k == n - 1);
            expected_reports.push_back(want);
         end
      endfunction

      function string describe_report(rsp_type r);
         return $sformatf("keys=%012h byte=%02h idx=%0d boot=%0b nkro=%0b busy=%0b found=%0b mode=%0d last=%0b",
                          r.boot_keys, r.nkro_byte, r.byte_index, r.sent_boot, r.sent_nkro,
                          r.busy_res, r.found, r.mode_now, r.last);
      endfunction

      function void check_report(rsp_type got);
         rsp_type want;
         checked++;
         if (expected_reports.size() == 0) begin
            failures++;
            if (failures <= MAX_SHOWN)
               $display("result %0d with nothing outstanding: %s", checked, describe_report(got));
            return;
         end
         want = expected_reports.pop_front();
         if (got.boot_keys !== want.boot_keys || got.nkro_byte !== want.nkro_byte ||
             got.byte_index !== want.byte_index || got.sent_boot !== want.sent_boot ||
             got.sent_nkro !== want.sent_nkro || got.busy_res !== want.busy_res ||
             got.found !== want.found || got.mode_now !== want.mode_now ||
             got.last !== want.last) begin
            failures++;
            if (failures <= MAX_SHOWN) begin
               $display("mismatch on result %0d", checked);
               $display("  expected %s", describe_report(want));
               $display("  actual   %s", describe_report(got));
            end
         end
      endfunction

      function int outstanding();
         return expected_reports.size();
      endfunction

   endclass

endpackage

// ----- verif/testbench.sv -----
// testbench: drives key events and sends into keyboard_report_slot_engine
// checks every response transaction against key_report_tracker, with random idling on both sides
// depends on krse_pkg and krse_report_tracker_pkg
`timescale 1ns / 1ps

module testbench;

   import krse_pkg::*;
   import krse_report_tracker_pkg::*;

   localparam int RANDOM_ITEMS    = 360;
   localparam int IDLE_PCT        = 25;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 100;
   // a long hold-off plus a full nkro send under random stalls stays far below this
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam logic [7:0] POOL_FIRST = 8'h04;
   localparam logic [7:0] POOL_LAST  = 8'h0F;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   key_report_tracker tracker = new();

   int req_idle_pct   = IDLE_PCT;
   int rsp_idle_pct   = IDLE_PCT;
   int hold_off_asked = 0;
   int counted_items  = 0;
   int quiet_cycles   = 0;

   keyboard_report_slot_engine #(
      .SLOTS        (NUM_SLOTS),
      .BITMAP_BYTES (NUM_BITMAP_BYTES),
      .REPLAY_DEPTH (NUM_REPLAY)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic bit chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // mostly a small pool of keys so that deletes hit and the six slots fill up,
   // now and then zero or any keycode at all
   function automatic logic [7:0] pick_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 75) return 8'($urandom_range(POOL_LAST, POOL_FIRST));
      if (roll < 80) return 8'h00;
      return 8'($urandom_range(255));
   endfunction

   // offer one request transaction and hold it until accepted
   task automatic issue(input kind_type kind, input logic [7:0] keycode,
                        input bit boot_rdy = 1'b1, input bit nkro_rdy = 1'b1,
                        input mode_type mode = MODE_AUTO);
      req_type item;
      item.kind       = kind;
      item.keycode    = keycode;
      item.boot_ready = boot_rdy;
      item.nkro_ready = nkro_rdy;
      // new_mode only matters for set mode, elsewhere it is noise
      item.new_mode   = (kind == KIND_SET_MODE) ? mode : mode_type'($urandom_range(3));
      // zero-key add and delete are ignored by the block, so they do not count
      if (!((kind == KIND_ADD || kind == KIND_DELETE) && keycode == 8'h00))
         counted_items++;
      @(negedge clock);
      while (chance(req_idle_pct)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver side: random stalls, and one long hold-off on request so the
   // engine fills up and pushes back on the request channel
   initial begin
      int served;
      served    = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_asked > served) begin
            served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall <= chance(rsp_idle_pct);
         end
      end
   end

   // transaction monitors and watchdog, all on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (req_valid && !req_stall) begin
            tracker.note_request(req_data);
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_report(rsp_data);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, tracker.outstanding());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int kc;
      int roll;
      int pick;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      issue(KIND_SEND, 8'h00, 1'b1, 1'b1);       // clean send, nothing posted
      issue(KIND_QUERY, 8'h00);                  // zero key found in an empty slot
      issue(KIND_ADD, 8'h00);                    // zero key ignored
      issue(KIND_DELETE, 8'h00);
      for (kc = 4; kc <= 9; kc++) issue(KIND_ADD, 8'(kc));
      issue(KIND_ADD, 8'hFF);                    // slots full, auto goes to upgrade
      issue(KIND_QUERY, 8'hFF);                  // upgrade still searches the slots
      issue(KIND_SEND, 8'h00, 1'b0, 1'b1);       // nkro posted, boot busy
      issue(KIND_RETRIGGER, 8'h05);
      issue(KIND_RETRIGGER, 8'h00);              // zero key goes on the replay list
      issue(KIND_SEND, 8'h00, 1'b1, 1'b1);       // both posted, list replayed
      issue(KIND_CLEAR, 8'h00);
      issue(KIND_SEND, 8'h00, 1'b1, 1'b1);       // empty slots move upgrade to nkro
      issue(KIND_ADD, 8'h80);
      issue(KIND_QUERY, 8'h80);                  // nkro query reads the bitmap
      issue(KIND_DELETE, 8'h04);                 // nkro delete leaves slots and ages
      issue(KIND_SET_MODE, 8'h00, 1'b1, 1'b1, MODE_6KRO);
      issue(KIND_RESET_ALL, 8'hFF);
      issue(KIND_SET_MODE, 8'h00, 1'b1, 1'b1, MODE_NKRO);
      issue(KIND_SEND, 8'h00, 1'b1, 1'b0);       // nkro endpoint busy

      // random part, built from short scenarios
      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         // a long stretch with no idling on either side
         req_idle_pct = (counted_items >= 150 && counted_items < 230) ? 0 : IDLE_PCT;
         rsp_idle_pct = req_idle_pct;
         if (counted_items >= 60 && hold_off_asked == 0) hold_off_asked = 1;
         roll = $urandom_range(99);
         if (roll < 60) begin
            // typing: presses, releases and lookups, then a report
            repeat ($urandom_range(8, 1)) begin
               pick = $urandom_range(99);
               if (pick < 55) issue(KIND_ADD, pick_key());
               else if (pick < 85) issue(KIND_DELETE, pick_key());
               else issue(KIND_QUERY, pick_key());
            end
            issue(KIND_SEND, pick_key(), chance(80), chance(80));
         end else if (roll < 70) begin
            // retrigger run, long enough to overflow the replay list at times
            repeat ($urandom_range(9, 4)) issue(KIND_RETRIGGER, pick_key());
            issue(KIND_SEND, pick_key(), chance(80), chance(80));
         end else if (roll < 80) begin
            issue(KIND_SET_MODE, pick_key(), 1'b1, 1'b1, mode_type'($urandom_range(3)));
         end else begin
            // noise: any kind with any fields
            issue(kind_type'($urandom_range(7)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)),
                  mode_type'($urandom_range(3)));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // wait for the last response transaction, then look for strays
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
